// File: sv/ole_pkg.sv
`default_nettype none
package ole_pkg;

   localparam int CAPACITY = 16;
   localparam int DATA_W   = 32;
   localparam int CMD_W    = 3;
   localparam int POS_W    = 8;
   localparam int ST_W     = 3;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);

   typedef enum logic [CMD_W-1:0] {
      CMD_INS_FRONT = 3'd0,
      CMD_INS_BACK  = 3'd1,
      CMD_INS_AT    = 3'd2,
      CMD_DEL_FRONT = 3'd3,
      CMD_DEL_BACK  = 3'd4,
      CMD_DEL_AT    = 3'd5,
      CMD_SEARCH    = 3'd6
   } cmd_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_RANGE    = 3'd2,
      ST_FULL     = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_INSERT,
      OP_DELETE,
      OP_SEARCH
   } op_type;

   typedef enum logic [1:0] {
      RD_IDX,
      RD_IDX_DEC,
      RD_IDX_INC,
      RD_EPOS
   } rd_sel_type;

   typedef enum logic {
      WR_SHIFT,
      WR_VALUE
   } wr_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_INS_CHK,
      S_INS_WR,
      S_DEL_RD,
      S_DEL_CAP,
      S_DEL_CHK,
      S_DEL_WR,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic       load_req;
      logic       idx_load_count;
      logic       idx_load_epos;
      logic       idx_load_zero;
      logic       idx_inc;
      logic       idx_dec;
      logic       mem_rd;
      rd_sel_type rd_sel;
      logic       mem_wr;
      wr_sel_type wr_sel;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       st_load;
      status_type st_code;
      logic       removed_load;
      logic       found_load;
      logic       rsp_load;
   } ctl_type;

   typedef struct packed {
      op_type     op;
      status_type pre_status;
      logic       idx_gt_epos;
      logic       idx_inc_lt_count;
      logic       idx_inc_eq_count;
      logic       match;
      logic       out_free;
   } sts_type;

endpackage
`default_nettype wire

// File: sv/ole_ctrl.sv
`default_nettype none
module ole_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ole_pkg::sts_type sts,
   output ole_pkg::ctl_type      ctl
);
   import ole_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      ctl       = '0;
      ctl.rd_sel  = RD_IDX;
      ctl.wr_sel  = WR_SHIFT;
      ctl.st_code = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            ctl.st_load = 1'b1;
            ctl.st_code = sts.pre_status;
            if (sts.pre_status != ST_OK || sts.op == OP_NONE) begin
               state_in = S_FINISH;
            end else if (sts.op == OP_INSERT) begin
               ctl.idx_load_count = 1'b1;
               state_in           = S_INS_CHK;
            end else if (sts.op == OP_DELETE) begin
               state_in = S_DEL_RD;
            end else begin
               ctl.idx_load_zero = 1'b1;
               state_in          = S_SRCH_RD;
            end
         end
         S_INS_CHK: begin
            if (sts.idx_gt_epos) begin
               ctl.mem_rd = 1'b1;
               ctl.rd_sel = RD_IDX_DEC;
               state_in   = S_INS_WR;
            end else begin
               ctl.mem_wr  = 1'b1;
               ctl.wr_sel  = WR_VALUE;
               ctl.cnt_inc = 1'b1;
               state_in    = S_FINISH;
            end
         end
         S_INS_WR: begin
            ctl.mem_wr  = 1'b1;
            ctl.wr_sel  = WR_SHIFT;
            ctl.idx_dec = 1'b1;
            state_in    = S_INS_CHK;
         end
         S_DEL_RD: begin
            ctl.mem_rd        = 1'b1;
            ctl.rd_sel        = RD_EPOS;
            ctl.idx_load_epos = 1'b1;
            state_in          = S_DEL_CAP;
         end
         S_DEL_CAP: begin
            ctl.removed_load = 1'b1;
            state_in         = S_DEL_CHK;
         end
         S_DEL_CHK: begin
            if (sts.idx_inc_lt_count) begin
               ctl.mem_rd = 1'b1;
               ctl.rd_sel = RD_IDX_INC;
               state_in   = S_DEL_WR;
            end else begin
               ctl.cnt_dec = 1'b1;
               state_in    = S_FINISH;
            end
         end
         S_DEL_WR: begin
            ctl.mem_wr  = 1'b1;
            ctl.wr_sel  = WR_SHIFT;
            ctl.idx_inc = 1'b1;
            state_in    = S_DEL_CHK;
         end
         S_SRCH_RD: begin
            ctl.mem_rd = 1'b1;
            ctl.rd_sel = RD_IDX;
            state_in   = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            if (sts.match) begin
               ctl.found_load = 1'b1;
               ctl.st_load    = 1'b1;
               ctl.st_code    = ST_OK;
               state_in       = S_FINISH;
            end else if (sts.idx_inc_eq_count) begin
               ctl.st_load = 1'b1;
               ctl.st_code = ST_NOTFOUND;
               state_in    = S_FINISH;
            end else begin
               ctl.idx_inc = 1'b1;
               state_in    = S_SRCH_RD;
            end
         end
         S_FINISH: begin
            if (sts.out_free) begin
               ctl.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: sv/ole_datapath.sv
`default_nettype none
module ole_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire ole_pkg::ctl_type                    ctl,
   output ole_pkg::sts_type                         sts,
   input  wire logic        [ole_pkg::CMD_W-1:0]    req_cmd,
   input  wire logic signed [ole_pkg::DATA_W-1:0]   req_value,
   input  wire logic        [ole_pkg::POS_W-1:0]    req_position,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic             [ole_pkg::ST_W-1:0]     rsp_status,
   output logic signed      [ole_pkg::DATA_W-1:0]   rsp_removed_value,
   output logic             [ole_pkg::POS_W-1:0]    rsp_found_position,
   output logic             [ole_pkg::POS_W-1:0]    rsp_entry_count
);
   import ole_pkg::*;

   logic [DATA_W-1:0] mem [CAPACITY];

   cmd_type           cmd_ff, cmd_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [DATA_W-1:0] rdata_ff;
   status_type        status_ff, status_in;
   logic [DATA_W-1:0] removed_ff, removed_in;
   logic [POS_W-1:0]  found_ff, found_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff;
   logic [DATA_W-1:0] rsp_removed_ff;
   logic [POS_W-1:0]  rsp_found_ff;
   logic [POS_W-1:0]  rsp_count_ff;

   logic [CNT_W-1:0]  epos;
   logic [CNT_W-1:0]  idx_p1;
   logic [CNT_W-1:0]  idx_m1;
   logic [POS_W-1:0]  count_ext;
   logic [CNT_W-1:0]  raddr_full;
   logic [CNT_W-1:0]  waddr_full;
   logic [DATA_W-1:0] wdata;

   assign count_ext = POS_W'(count_ff);
   assign idx_p1    = idx_ff + CNT_W'(1);
   assign idx_m1    = idx_ff - CNT_W'(1);

   always_comb begin
      sts.op         = OP_NONE;
      sts.pre_status = ST_OK;
      epos           = '0;
      unique case (cmd_ff) inside
         CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
            sts.op = OP_INSERT;
            if (count_ff == CNT_W'(CAPACITY)) begin
               sts.pre_status = ST_FULL;
            end else if (cmd_ff == CMD_INS_AT && pos_ff > count_ext) begin
               sts.pre_status = ST_RANGE;
            end
            if (cmd_ff == CMD_INS_BACK) begin
               epos = count_ff;
            end else if (cmd_ff == CMD_INS_AT) begin
               epos = pos_ff[CNT_W-1:0];
            end
         end
         CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
            sts.op = OP_DELETE;
            if (count_ff == '0) begin
               sts.pre_status = ST_EMPTY;
            end else if (cmd_ff == CMD_DEL_AT && pos_ff >= count_ext) begin
               sts.pre_status = ST_RANGE;
            end
            if (cmd_ff == CMD_DEL_BACK) begin
               epos = count_ff - CNT_W'(1);
            end else if (cmd_ff == CMD_DEL_AT) begin
               epos = pos_ff[CNT_W-1:0];
            end
         end
         CMD_SEARCH: begin
            sts.op = OP_SEARCH;
            if (count_ff == '0) begin
               sts.pre_status = ST_NOTFOUND;
            end
         end
         default: begin
            sts.op = OP_NONE;
         end
      endcase
      sts.idx_gt_epos      = (idx_ff > epos);
      sts.idx_inc_lt_count = (idx_p1 < count_ff);
      sts.idx_inc_eq_count = (idx_p1 == count_ff);
      sts.match            = (rdata_ff == value_ff);
      sts.out_free         = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      unique case (ctl.rd_sel)
         RD_IDX_DEC: raddr_full = idx_m1;
         RD_IDX_INC: raddr_full = idx_p1;
         RD_EPOS:    raddr_full = epos;
         default:    raddr_full = idx_ff;
      endcase
      if (ctl.wr_sel == WR_VALUE) begin
         waddr_full = epos;
         wdata      = value_ff;
      end else begin
         waddr_full = idx_ff;
         wdata      = rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mem_wr) begin
         mem[waddr_full[IDX_W-1:0]] <= wdata;
      end
      if (ctl.mem_rd) begin
         rdata_ff <= mem[raddr_full[IDX_W-1:0]];
      end
   end

   always_comb begin
      cmd_in     = cmd_ff;
      value_in   = value_ff;
      pos_in     = pos_ff;
      status_in  = status_ff;
      removed_in = removed_ff;
      found_in   = found_ff;
      if (ctl.load_req) begin
         cmd_in     = cmd_type'(req_cmd);
         value_in   = req_value;
         pos_in     = req_position;
         status_in  = ST_OK;
         removed_in = '0;
         found_in   = '0;
      end
      if (ctl.st_load) begin
         status_in = ctl.st_code;
      end
      if (ctl.removed_load) begin
         removed_in = rdata_ff;
      end
      if (ctl.found_load) begin
         found_in = POS_W'(idx_ff);
      end

      idx_in = idx_ff;
      if (ctl.idx_load_count) begin
         idx_in = count_ff;
      end else if (ctl.idx_load_epos) begin
         idx_in = epos;
      end else if (ctl.idx_load_zero) begin
         idx_in = '0;
      end else if (ctl.idx_inc) begin
         idx_in = idx_p1;
      end else if (ctl.idx_dec) begin
         idx_in = idx_m1;
      end

      count_in = count_ff;
      if (ctl.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctl.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      value_ff   <= value_in;
      pos_ff     <= pos_in;
      idx_ff     <= idx_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
      found_ff   <= found_in;
      if (ctl.rsp_load) begin
         rsp_status_ff  <= status_ff;
         rsp_removed_ff <= removed_ff;
         rsp_found_ff   <= found_ff;
         rsp_count_ff   <= count_ext;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_removed_value  = rsp_removed_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_entry_count    = rsp_count_ff;

endmodule
`default_nettype wire

// File: sv/ordered_list_engine_unit.sv
// Ordered list of up to CAPACITY signed 32-bit entries.
// Request channel (req_valid/req_stall): req_cmd selects insert front, insert back,
// insert at req_position, delete front, delete back, delete at req_position, or
// search for req_value. Each request yields exactly one response on the rsp_
// channel: status, removed value, found position and entry count after the request.
// One request is worked at a time; req_stall stays high from acceptance until the
// response is placed in the output register. Entries move through a single-port
// entry memory, one entry at a time, each read and then written back. A rejected
// request or an unused code is the quickest; a delete at the front of a full list
// is the slowest, counted from acceptance to the next acceptance.
// The output register holds one response; while rsp_stall holds it, a new request
// is still accepted and worked, and its response waits until the register frees.
// Synchronous reset empties the list and drops any pending response; entry
// contents are not cleared and are never read before being written.
`default_nettype none
module ordered_list_engine_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic        [ole_pkg::CMD_W-1:0]   req_cmd,
   input  wire logic signed [ole_pkg::DATA_W-1:0]  req_value,
   input  wire logic        [ole_pkg::POS_W-1:0]   req_position,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic             [ole_pkg::ST_W-1:0]    rsp_status,
   output logic signed      [ole_pkg::DATA_W-1:0]  rsp_removed_value,
   output logic             [ole_pkg::POS_W-1:0]   rsp_found_position,
   output logic             [ole_pkg::POS_W-1:0]   rsp_entry_count
);
   import ole_pkg::*;

   ctl_type ctl;
   sts_type sts;

   ole_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   ole_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .sts                (sts),
      .req_cmd            (req_cmd),
      .req_value          (req_value),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_removed_value  (rsp_removed_value),
      .rsp_found_position (rsp_found_position),
      .rsp_entry_count    (rsp_entry_count)
   );

endmodule
`default_nettype wire

// File: tb/ordered_list_engine_unit_tb.sv
module ordered_list_engine_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ole_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
   localparam int PHASES       = 3;
   localparam int LAST_PHASE   = PHASES - 1;
   localparam int PHASE_ITEMS  = 600;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 2 * CAPACITY + 30;
   localparam int QUIET_LIMIT  = 2000;

   typedef struct packed {
      logic [ST_W-1:0]          status;
      logic signed [DATA_W-1:0] removed;
      logic [POS_W-1:0]         found;
      logic [POS_W-1:0]         count;
   } outcome_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [DATA_W-1:0] value;
      logic [POS_W-1:0]  pos;
      logic [7:0]        reps;
      logic              typed;
      outcome_type       want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [CMD_W-1:0] req_cmd = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic [POS_W-1:0] req_position = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [ST_W-1:0] rsp_status;
   logic signed [DATA_W-1:0] rsp_removed_value;
   logic [POS_W-1:0] rsp_found_position;
   logic [POS_W-1:0] rsp_entry_count;

   logic signed [DATA_W-1:0] shadow_list[$];
   outcome_type pending_outcomes[$];
   row_type directed_rows[$];
   int mismatches = 0;
   int phase = 0;
   int tx_idle_pct[PHASES] = '{28, 77, 0};
   int rx_idle_pct[PHASES] = '{77, 28, 0};
   bit hold_done = 1'b0;
   int quiet_cycles = 0;

   ordered_list_engine_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_value(req_value),
      .req_position(req_position),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_removed_value(rsp_removed_value),
      .rsp_found_position(rsp_found_position),
      .rsp_entry_count(rsp_entry_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic outcome_type apply_list_cmd(logic [CMD_W-1:0] cmd,
                                                  logic signed [DATA_W-1:0] value,
                                                  logic [POS_W-1:0] pos);
      outcome_type o;
      int n;
      int at;
      bit hit;
      o = '0;
      o.status = ST_OK;
      n = shadow_list.size();
      hit = 1'b0;
      case (cmd)
         CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
            at = (cmd == CMD_INS_FRONT) ? 0 : (cmd == CMD_INS_BACK) ? n : int'(pos);
            if (n >= CAPACITY)
               o.status = ST_FULL;
            else if (at > n)
               o.status = ST_RANGE;
            else
               shadow_list.insert(at, value);
         end
         CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
            at = (cmd == CMD_DEL_FRONT) ? 0 : (cmd == CMD_DEL_BACK) ? n - 1 : int'(pos);
            if (n == 0)
               o.status = ST_EMPTY;
            else if (at >= n)
               o.status = ST_RANGE;
            else begin
               o.removed = shadow_list[at];
               shadow_list.delete(at);
            end
         end
         CMD_SEARCH: begin
            o.status = ST_NOTFOUND;
            for (int i = 0; i < n && !hit; i++) begin
               if (shadow_list[i] == value) begin
                  hit = 1'b1;
                  o.status = ST_OK;
                  o.found = POS_W'(i);
               end
            end
         end
         default: ;
      endcase
      o.count = POS_W'(shadow_list.size());
      return o;
   endfunction

   task automatic send_request(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] value,
                               logic [POS_W-1:0] pos, logic typed, outcome_type want);
      outcome_type predicted;
      while ($urandom_range(99) < tx_idle_pct[phase]) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_value    <= value;
      req_position <= pos;
      do @(posedge clock); while (req_stall);
      predicted = apply_list_cmd(cmd, value, pos);
      pending_outcomes.push_back(typed ? want : predicted);
   endtask

   task automatic add_row(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value,
                          logic [POS_W-1:0] pos, logic [7:0] reps, logic typed,
                          logic [ST_W-1:0] st, logic [DATA_W-1:0] rem,
                          logic [POS_W-1:0] fnd, logic [POS_W-1:0] cnt);
      row_type r;
      r.cmd          = cmd;
      r.value        = value;
      r.pos          = pos;
      r.reps         = reps;
      r.typed        = typed;
      r.want.status  = st;
      r.want.removed = rem;
      r.want.found   = fnd;
      r.want.count   = cnt;
      directed_rows.push_back(r);
   endtask

   task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h got %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: response expected none got status %h count %h", $time,
                     rsp_status, rsp_entry_count);
            mismatches++;
         end else begin
            want = pending_outcomes.pop_front();
            check_field("status", DATA_W'(want.status), DATA_W'(rsp_status));
            check_field("removed_value", want.removed, rsp_removed_value);
            check_field("found_position", DATA_W'(want.found), DATA_W'(rsp_found_position));
            check_field("entry_count", DATA_W'(want.count), DATA_W'(rsp_entry_count));
         end
      end
   end

   initial begin
      forever begin
         if (phase == LAST_PHASE && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < rx_idle_pct[phase]);
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      row_type r;
      logic [CMD_W-1:0] cmd;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0] pos;
      int n;
      int r_pick;
      int ins_pct;

      add_row(CMD_DEL_FRONT, 0, 0, 1, 1, ST_EMPTY, 0, 0, 0);
      add_row(CMD_DEL_BACK, 0, 0, 1, 1, ST_EMPTY, 0, 0, 0);
      add_row(CMD_DEL_AT, 0, 0, 1, 1, ST_EMPTY, 0, 0, 0);
      add_row(CMD_SEARCH, 0, 0, 1, 1, ST_NOTFOUND, 0, 0, 0);
      add_row(CMD_INS_AT, 7, 1, 1, 1, ST_RANGE, 0, 0, 0);
      add_row(CMD_INS_AT, 32'h8000_0000, 0, 1, 1, ST_OK, 0, 0, 1);
      add_row(CMD_INS_BACK, 32'h7fff_ffff, 8'hff, 1, 1, ST_OK, 0, 0, 2);
      add_row(CMD_INS_FRONT, 32'hffff_ffff, 8'hff, 1, 1, ST_OK, 0, 0, 3);
      add_row(CMD_UNUSED, 32'h1234_5678, 8'hff, 1, 1, ST_OK, 0, 0, 3);
      add_row(CMD_SEARCH, 32'h7fff_ffff, 0, 1, 1, ST_OK, 0, 2, 3);
      add_row(CMD_INS_AT, 5, 3, 1, 1, ST_OK, 0, 0, 4);
      add_row(CMD_INS_AT, 9, 8'hff, 1, 1, ST_RANGE, 0, 0, 4);
      add_row(CMD_DEL_AT, 0, 8'hff, 1, 1, ST_RANGE, 0, 0, 4);
      add_row(CMD_DEL_AT, 0, 4, 1, 1, ST_RANGE, 0, 0, 4);
      add_row(CMD_DEL_AT, 0, 1, 1, 1, ST_OK, 32'h8000_0000, 0, 3);
      add_row(CMD_DEL_FRONT, 0, 0, 1, 1, ST_OK, 32'hffff_ffff, 0, 2);
      add_row(CMD_DEL_BACK, 0, 0, 1, 1, ST_OK, 5, 0, 1);
      add_row(CMD_INS_BACK, 100, 0, 8'(CAPACITY - 1), 0, ST_OK, 0, 0, 0);
      add_row(CMD_INS_FRONT, 1, 0, 1, 1, ST_FULL, 0, 0, POS_W'(CAPACITY));
      add_row(CMD_INS_AT, 1, 8'hff, 1, 1, ST_FULL, 0, 0, POS_W'(CAPACITY));
      add_row(CMD_INS_BACK, 1, 0, 1, 1, ST_FULL, 0, 0, POS_W'(CAPACITY));
      add_row(CMD_SEARCH, 114, 0, 1, 0, ST_OK, 0, 0, 0);
      add_row(CMD_SEARCH, 0, 0, 1, 0, ST_OK, 0, 0, 0);
      add_row(CMD_DEL_AT, 0, POS_W'(CAPACITY - 1), 1, 0, ST_OK, 0, 0, 0);
      add_row(CMD_DEL_BACK, 0, 0, 8'(CAPACITY), 0, ST_OK, 0, 0, 0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         r = directed_rows[k];
         for (int i = 0; i < r.reps; i++)
            send_request(r.cmd, r.value + i, r.pos, r.typed, r.want);
      end

      for (phase = 0; phase < PHASES; phase++) begin
         ins_pct = 45;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k % 40 == 0)
               ins_pct = ($urandom_range(2) == 0) ? 62 : ($urandom_range(1) == 0) ? 30 : 45;
            n = shadow_list.size();
            r_pick = $urandom_range(99);
            if (r_pick < 2)
               cmd = CMD_UNUSED;
            else if (r_pick < ins_pct)
               cmd = ($urandom_range(2) == 0) ? CMD_INS_FRONT :
                     ($urandom_range(1) == 0) ? CMD_INS_BACK : CMD_INS_AT;
            else if (r_pick < 88)
               cmd = ($urandom_range(2) == 0) ? CMD_DEL_FRONT :
                     ($urandom_range(1) == 0) ? CMD_DEL_BACK : CMD_DEL_AT;
            else
               cmd = CMD_SEARCH;
            if ($urandom_range(3) == 0)
               value = $signed($urandom_range(7)) - 4;
            else
               value = $urandom();
            if (cmd == CMD_SEARCH && n > 0 && $urandom_range(9) < 7)
               value = shadow_list[$urandom_range(n - 1)];
            if ($urandom_range(99) < 85)
               pos = POS_W'($urandom_range(n + 1));
            else
               pos = POS_W'($urandom_range(255));
            send_request(cmd, value, pos, 1'b0, '0);
         end
      end
      phase = LAST_PHASE;

      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
